// ===== rtl/rgpm_pkg.sv =====
// Package for the range-gated point median unit.
// Shared constants, register and state codes, and control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgpm_pkg;

	localparam int COORD_BITS_DEF     = 16;
	localparam int POINT_CAPACITY_DEF = 256;

	localparam int RANGE_W    = 15;
	localparam int RANGE_SQ_W = 2 * RANGE_W;
	localparam int CFG_IDX_W  = 1;

	localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 15'd128;    // 0.5 m
	localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 15'd10240;  // 40 m

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_RANGE,
		REG_MAX_RANGE
	} rgpm_reg_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} rgpm_state_t;

	// per-cycle command broadcast to every sort cell
	typedef struct packed {
		logic ins;
		logic drain;
	} rgpm_cell_ctl_t;

	// status of the point leaving the range gate pipeline
	typedef struct packed {
		logic valid;
		logic keep;
		logic last;
	} rgpm_gate_st_t;

endpackage

`default_nettype wire

// ===== rtl/rgpm_ifs.sv =====
// Valid/ready channel interfaces for points in and cloud results out.
// Widths follow the top-level parameters; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface rgpm_pt_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic signed [COORD_BITS-1:0] coord_z;
	logic                         last_point;

	modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
	modport sink   (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

interface rgpm_res_if #(
	parameter int COORD_BITS = 16,
	parameter int CNT_W      = 9
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] median_x;
	logic signed [COORD_BITS-1:0] median_y;
	logic [CNT_W-1:0]             kept_count;
	logic                         found;
	logic                         overflowed;

	modport source (output valid, median_x, median_y, kept_count, found, overflowed,
		input ready);
	modport sink   (input valid, median_x, median_y, kept_count, found, overflowed,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/rgpm_gate.sv =====
// Range gate: three-stage pipeline (squares, sum, window compare).
// Depends on rgpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgpm_gate #(
	parameter int COORD_BITS = rgpm_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic signed [COORD_BITS-1:0]         x,
	input  logic signed [COORD_BITS-1:0]         y,
	input  logic signed [COORD_BITS-1:0]         z,
	input  logic                                 last,
	input  logic [rgpm_pkg::RANGE_W-1:0]         min_range,
	input  logic [rgpm_pkg::RANGE_W-1:0]         max_range,
	output rgpm_pkg::rgpm_gate_st_t              st,
	output logic signed [COORD_BITS-1:0]         x_out,
	output logic signed [COORD_BITS-1:0]         y_out
);
	import rgpm_pkg::*;

	localparam int SQ_W  = 2 * COORD_BITS - 1;
	localparam int SUM_W = SQ_W + 2;
	localparam int CMP_W = (SUM_W > RANGE_SQ_W) ? SUM_W : RANGE_SQ_W;

	logic signed [2*COORD_BITS-1:0] px, py, pz;

	logic                         valid_s1, last_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1;
	logic [SQ_W-1:0]              sqx_s1, sqy_s1, sqz_s1;

	logic                         valid_s2, last_s2;
	logic signed [COORD_BITS-1:0] x_s2, y_s2;
	logic [SUM_W-1:0]             sum_s2;

	logic                         valid_s3, last_s3, keep_s3;
	logic signed [COORD_BITS-1:0] x_s3, y_s3;

	logic [RANGE_SQ_W-1:0] min_sq_q, max_sq_q;

	assign px = x * x;
	assign py = y * y;
	assign pz = z * z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// gate thresholds are to be changed only while idle; the gate itself does not enforce this
	always_ff @(posedge clk) begin
		min_sq_q <= RANGE_SQ_W'(min_range) * RANGE_SQ_W'(min_range);
		max_sq_q <= RANGE_SQ_W'(max_range) * RANGE_SQ_W'(max_range);
	end

	always_ff @(posedge clk) begin
		last_s1 <= last;
		x_s1    <= x;
		y_s1    <= y;
		sqx_s1  <= px[SQ_W-1:0];
		sqy_s1  <= py[SQ_W-1:0];
		sqz_s1  <= pz[SQ_W-1:0];

		last_s2 <= last_s1;
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		sum_s2  <= SUM_W'(sqx_s1) + SUM_W'(sqy_s1) + SUM_W'(sqz_s1);

		last_s3 <= last_s2;
		x_s3    <= x_s2;
		y_s3    <= y_s2;
		keep_s3 <= (CMP_W'(sum_s2) > CMP_W'(min_sq_q)) &&
			(CMP_W'(sum_s2) < CMP_W'(max_sq_q));
	end

	assign st.valid = valid_s3;
	assign st.keep  = keep_s3;
	assign st.last  = last_s3;
	assign x_out    = x_s3;
	assign y_out    = y_s3;

endmodule

`default_nettype wire

// ===== rtl/rgpm_cell.sv =====
// One sort cell: holds a single value of the ascending row.
// Insert shifts right past larger values; drain shifts left. Depends on rgpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgpm_cell #(
	parameter int W = rgpm_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  rgpm_pkg::rgpm_cell_ctl_t ctl,
	input  logic                    occ,
	input  logic signed [W-1:0]     new_val,
	input  logic signed [W-1:0]     left_val,
	input  logic                    left_gt,
	input  logic signed [W-1:0]     right_val,
	output logic signed [W-1:0]     val,
	output logic                    gt
);
	import rgpm_pkg::*;

	logic signed [W-1:0] val_q;

	// an empty cell counts as greater so the new value lands at the end;
	// strict compare puts equal values after the stored ones
	assign gt  = !occ || (val_q > new_val);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			val_q <= right_val;
		end else if (ctl.ins && gt) begin
			val_q <= left_gt ? left_val : new_val;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rgpm_chain.sv =====
// Row of sort cells for one coordinate, kept in ascending order.
// Depends on rgpm_pkg and rgpm_cell.
`timescale 1ns / 1ps
`default_nettype none

module rgpm_chain #(
	parameter int DEPTH = rgpm_pkg::POINT_CAPACITY_DEF,
	parameter int W     = rgpm_pkg::COORD_BITS_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  rgpm_pkg::rgpm_cell_ctl_t ctl,
	input  logic [CNT_W-1:0]         count,
	input  logic signed [W-1:0]      new_val,
	output logic signed [W-1:0]      head
);
	import rgpm_pkg::*;

	logic signed [W-1:0] vals [DEPTH];
	logic [DEPTH-1:0]    gts;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [W-1:0] lv, rv;
		logic                lg;

		if (i == 0) begin : g_first
			assign lv = '0;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lv = vals[i-1];
			assign lg = gts[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign rv = vals[i];
		end else begin : g_inner
			assign rv = vals[i+1];
		end

		rgpm_cell #(
			.W (W)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (CNT_W'(i) < count),
			.new_val   (new_val),
			.left_val  (lv),
			.left_gt   (lg),
			.right_val (rv),
			.val       (vals[i]),
			.gt        (gts[i])
		);
	end

	assign head = vals[0];

endmodule

`default_nettype wire

// ===== rtl/range_gated_point_median_unit.sv =====
// Top level of the range-gated point median unit.
// Depends on rgpm_pkg, rgpm_ifs, rgpm_gate, rgpm_chain (rgpm_cell).
//
//   channel | dir | handshake   | payload
//   pts     | in  | valid/ready | coord_x, coord_y, coord_z, last_point
//   res     | out | valid/ready | median_x, median_y, kept_count, found, overflowed
//   cfg     | in  | cfg_we      | cfg_idx, cfg_data (min_range, max_range)
//
// Points are taken one per cycle while pts.ready is high; each passes a
// 3-stage range gate and is inserted into two rows of sort cells (x and y).
// After the last point leaves the gate, the rows shift toward cell 0 by
// kept_count/2 places, then the result register is loaded once it is free.
// pts.ready stays low from the last point until its result is registered.
// A result waiting in the output register stalls only the next cloud's end.
// Reset clears control state and sets the range gates to 0.5 m and 40 m.
`timescale 1ns / 1ps
`default_nettype none

module range_gated_point_median_unit #(
	parameter int POINT_CAPACITY = rgpm_pkg::POINT_CAPACITY_DEF,
	parameter int COORD_BITS     = rgpm_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rgpm_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [rgpm_pkg::RANGE_W-1:0]       cfg_data,
	rgpm_pt_if.sink                            pts,
	rgpm_res_if.source                         res
);
	import rgpm_pkg::*;

	localparam int CNT_W = $clog2(POINT_CAPACITY + 1);

	rgpm_state_t state_q, state_d;
	rgpm_cell_ctl_t ctl;
	rgpm_gate_st_t  g_st;

	logic [RANGE_W-1:0] min_range_q, max_range_q;
	logic [CNT_W-1:0]   kept_q, drain_q, kept_next;
	logic               ovf_q, last_seen_q, capture, full;

	logic signed [COORD_BITS-1:0] gx, gy, head_x, head_y;

	logic                         res_valid_q;
	logic signed [COORD_BITS-1:0] median_x_q, median_y_q;
	logic [CNT_W-1:0]             kept_count_q;
	logic                         found_q, overflowed_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q <= MIN_RANGE_RST;
			max_range_q <= MAX_RANGE_RST;
		end else if (cfg_we) begin
			unique case (rgpm_reg_t'(cfg_idx))
				REG_MIN_RANGE: min_range_q <= cfg_data;
				REG_MAX_RANGE: max_range_q <= cfg_data;
			endcase
		end
	end

	assign pts.ready = (state_q == ST_LOAD) && !last_seen_q;

	rgpm_gate #(
		.COORD_BITS (COORD_BITS)
	) u_gate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pts.valid && pts.ready),
		.x         (pts.coord_x),
		.y         (pts.coord_y),
		.z         (pts.coord_z),
		.last      (pts.last_point),
		.min_range (min_range_q),
		.max_range (max_range_q),
		.st        (g_st),
		.x_out     (gx),
		.y_out     (gy)
	);

	rgpm_chain #(
		.DEPTH (POINT_CAPACITY),
		.W     (COORD_BITS),
		.CNT_W (CNT_W)
	) u_chain_x (
		.clk     (clk),
		.ctl     (ctl),
		.count   (kept_q),
		.new_val (gx),
		.head    (head_x)
	);

	rgpm_chain #(
		.DEPTH (POINT_CAPACITY),
		.W     (COORD_BITS),
		.CNT_W (CNT_W)
	) u_chain_y (
		.clk     (clk),
		.ctl     (ctl),
		.count   (kept_q),
		.new_val (gy),
		.head    (head_y)
	);

	assign full      = (kept_q == CNT_W'(POINT_CAPACITY));
	assign kept_next = kept_q + CNT_W'(ctl.ins);

	always_comb begin
		state_d   = state_q;
		ctl.ins   = 1'b0;
		ctl.drain = 1'b0;
		capture   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				ctl.ins = g_st.valid && g_st.keep && !full;
				if (g_st.valid && g_st.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q != '0) begin
					ctl.drain = 1'b1;
				end else if (!res_valid_q || res.ready) begin
					capture = 1'b1;
					state_d = ST_LOAD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			kept_q      <= '0;
			ovf_q       <= 1'b0;
			last_seen_q <= 1'b0;
			drain_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (pts.valid && pts.ready && pts.last_point) begin
				last_seen_q <= 1'b1;
			end

			if (state_q == ST_LOAD && g_st.valid) begin
				kept_q <= kept_next;
				if (g_st.keep && full) begin
					ovf_q <= 1'b1;
				end
				if (g_st.last) begin
					drain_q <= kept_next >> 1;
				end
			end

			if (ctl.drain) begin
				drain_q <= drain_q - 1'b1;
			end

			if (capture) begin
				kept_q      <= '0;
				ovf_q       <= 1'b0;
				last_seen_q <= 1'b0;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// median sits in cell 0 once the rows have drained
	always_ff @(posedge clk) begin
		if (capture) begin
			median_x_q   <= (kept_q != '0) ? head_x : '0;
			median_y_q   <= (kept_q != '0) ? head_y : '0;
			kept_count_q <= kept_q;
			found_q      <= (kept_q != '0);
			overflowed_q <= ovf_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.median_x   = median_x_q;
	assign res.median_y   = median_y_q;
	assign res.kept_count = kept_count_q;
	assign res.found      = found_q;
	assign res.overflowed = overflowed_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= CNT_W'(POINT_CAPACITY))
		else $error("kept count above capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> full)
		else $error("overflow flagged with room left");

	a_no_take_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> !pts.ready)
		else $error("point taken while draining");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (drain_q <= (kept_q >> 1)))
		else $error("drain count beyond median rank");

endmodule

`default_nettype wire
